FILE: design/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset
`define FQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define FQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/fq_pkg.sv
package fq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ID_W  = 8;
  localparam int CAT_W = 8;
  localparam int PRI_W = 8;
  localparam int REF_W = 32;
  localparam int STAT_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
    logic [CAT_W-1:0] cat;
    logic [REF_W-1:0] hnd;
    logic [REF_W-1:0] par;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_PLACE,
    S_HEAD,
    S_MOVE,
    S_FINISH
  } fq_state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_LAST,
    RD_BELOW2,
    RD_HEAD,
    RD_NEXT1,
    RD_AHEAD
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_NEW,
    WR_DOWN
  } wr_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_ONE,
    IDX_DEC,
    IDX_INC
  } idx_op_t;

  typedef struct packed {
    logic              ready;
    logic              load;
    rd_sel_t           rd_sel;
    wr_sel_t           wr_sel;
    idx_op_t           idx_op;
    logic              capture_head;
    logic              set_status;
    logic [STAT_W-1:0] status_val;
    logic              finish;
  } fq_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic op;
    logic full;
    logic empty;
    logic hnd_zero;
    logic greater;
    logic idx_one;
    logic more;
    logic multi;
    logic out_busy;
  } fq_stat_t;

endpackage

FILE: design/fq_if.sv
interface fq_in_if;
  import fq_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [ID_W-1:0]  fault_num;
  logic [CAT_W-1:0] category;
  logic [PRI_W-1:0] priority_req;
  logic [REF_W-1:0] handler_ref;
  logic [REF_W-1:0] param_ref;

  modport source (
    output valid, op, fault_num, category, priority_req, handler_ref, param_ref,
    input  ready
  );

  modport sink (
    input  valid, op, fault_num, category, priority_req, handler_ref, param_ref,
    output ready
  );
endinterface

interface fq_out_if #(parameter int CNT_W = 5);
  import fq_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_id;
  logic [CAT_W-1:0]  out_category;
  logic [PRI_W-1:0]  out_priority;
  logic [REF_W-1:0]  out_handler;
  logic [REF_W-1:0]  out_param;
  logic [CNT_W-1:0]  count;

  modport source (
    output valid, status, out_id, out_category, out_priority, out_handler, out_param,
           count,
    input  ready
  );

  modport sink (
    input  valid, status, out_id, out_category, out_priority, out_handler, out_param,
           count,
    output ready
  );
endinterface

FILE: design/fq_ram.sv
module fq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/fq_ctrl.sv
module fq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  fq_pkg::fq_stat_t stat,
  output fq_pkg::fq_cmd_t  cmd
);
  import fq_pkg::*;

  fq_state_t state;
  fq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (stat.in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.op == OP_INSERT) begin
          if (stat.full || stat.hnd_zero) state_next = S_FINISH;
          else if (stat.empty)            state_next = S_PLACE;
          else                            state_next = S_SHIFT;
        end else begin
          if (stat.empty) state_next = S_FINISH;
          else            state_next = S_HEAD;
        end
      end
      S_SHIFT: begin
        if (!stat.greater)     state_next = S_FINISH;
        else if (stat.idx_one) state_next = S_PLACE;
      end
      S_PLACE: state_next = S_FINISH;
      S_HEAD: begin
        if (stat.multi) state_next = S_MOVE;
        else            state_next = S_FINISH;
      end
      S_MOVE: begin
        if (!stat.more) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready        = 1'b0;
    cmd.load         = 1'b0;
    cmd.rd_sel       = RD_NONE;
    cmd.wr_sel       = WR_NONE;
    cmd.idx_op       = IDX_HOLD;
    cmd.capture_head = 1'b0;
    cmd.set_status   = 1'b0;
    cmd.status_val   = STAT_OK;
    cmd.finish       = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        cmd.load  = stat.in_valid;
      end
      S_DECODE: begin
        if (stat.op == OP_INSERT) begin
          if (stat.full || stat.hnd_zero) begin
            cmd.set_status = 1'b1;
            cmd.status_val = STAT_REJECT;
          end else begin
            cmd.idx_op = IDX_COUNT;
            if (!stat.empty) cmd.rd_sel = RD_LAST;
          end
        end else begin
          if (stat.empty) begin
            cmd.set_status = 1'b1;
            cmd.status_val = STAT_EMPTY;
          end else begin
            cmd.rd_sel = RD_HEAD;
          end
        end
      end
      S_SHIFT: begin
        if (stat.greater) begin
          cmd.wr_sel = WR_UP;
          cmd.idx_op = IDX_DEC;
          if (!stat.idx_one) cmd.rd_sel = RD_BELOW2;
        end else begin
          cmd.wr_sel = WR_NEW;
        end
      end
      S_PLACE: cmd.wr_sel = WR_NEW;
      S_HEAD: begin
        cmd.capture_head = 1'b1;
        if (stat.multi) begin
          cmd.rd_sel = RD_NEXT1;
          cmd.idx_op = IDX_ONE;
        end
      end
      S_MOVE: begin
        cmd.wr_sel = WR_DOWN;
        if (stat.more) begin
          cmd.rd_sel = RD_AHEAD;
          cmd.idx_op = IDX_INC;
        end
      end
      S_FINISH: cmd.finish = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: design/fq_dp.sv
`include "assert_macros.svh"

module fq_dp #(
  parameter int QUEUE_DEPTH = fq_pkg::QUEUE_DEPTH_DEF,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  fq_in_if.sink            req,
  fq_out_if.source         rsp,
  input  fq_pkg::fq_cmd_t  cmd,
  output fq_pkg::fq_stat_t stat
);
  import fq_pkg::*;

  rec_t              item;
  logic              item_op;
  rec_t              head;
  logic [STAT_W-1:0] res_status;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     cnt_m1;
  logic [AW-1:0]     idx;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  rec_t              ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [REC_W-1:0]  ram_rdata;
  rec_t              rd_rec;

  assign rd_rec = rec_t'(ram_rdata);
  assign cnt_m1 = count_q - CW'(1);
  assign req.ready = cmd.ready;

  fq_ram #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    ram_re    = (cmd.rd_sel != RD_NONE);
    ram_raddr = '0;
    case (cmd.rd_sel)
      RD_LAST:   ram_raddr = cnt_m1[AW-1:0];
      RD_BELOW2: ram_raddr = idx - AW'(2);
      RD_HEAD:   ram_raddr = '0;
      RD_NEXT1:  ram_raddr = AW'(1);
      RD_AHEAD:  ram_raddr = idx + AW'(1);
      default:   ram_raddr = '0;
    endcase
  end

  always_comb begin
    ram_we    = (cmd.wr_sel != WR_NONE);
    ram_waddr = idx;
    ram_wdata = rd_rec;
    case (cmd.wr_sel)
      WR_UP:   ram_waddr = idx;
      WR_NEW: begin
        ram_waddr = idx;
        ram_wdata = item;
      end
      WR_DOWN: ram_waddr = idx - AW'(1);
      default: ram_waddr = idx;
    endcase
  end

  always_comb begin
    count_next = count_q;
    if (res_status == STAT_OK) begin
      if (item_op == OP_INSERT) count_next = count_q + CW'(1);
      else                      count_next = cnt_m1;
    end
  end

  always_comb begin
    stat.in_valid = req.valid;
    stat.op       = item_op;
    stat.full     = (count_q == CW'(QUEUE_DEPTH));
    stat.empty    = (count_q == '0);
    stat.hnd_zero = (item.hnd == '0);
    stat.greater  = (rd_rec.pri > item.pri);
    stat.idx_one  = (idx == AW'(1));
    stat.more     = ((CW'(idx) + CW'(1)) < count_q);
    stat.multi    = (count_q > CW'(1));
    stat.out_busy = rsp.valid && !rsp.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op    <= req.op;
      item.pri   <= req.priority_req;
      item.id    <= req.fault_num;
      item.cat   <= req.category;
      item.hnd   <= req.handler_ref;
      item.par   <= req.param_ref;
      head       <= '0;
      res_status <= STAT_OK;
    end else begin
      if (cmd.set_status) res_status <= cmd.status_val;
      if (cmd.capture_head) head <= rd_rec;
    end
    case (cmd.idx_op)
      IDX_COUNT: idx <= count_q[AW-1:0];
      IDX_ONE:   idx <= AW'(1);
      IDX_DEC:   idx <= idx - AW'(1);
      IDX_INC:   idx <= idx + AW'(1);
      default:   idx <= idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_q   <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.status       <= res_status;
      rsp.out_id       <= head.id;
      rsp.out_category <= head.cat;
      rsp.out_priority <= head.pri;
      rsp.out_handler  <= head.hnd;
      rsp.out_param    <= head.par;
      rsp.count        <= count_next;
    end
  end

  `FQ_ASSERT(a_count_range, (count_q <= CW'(QUEUE_DEPTH)), "record count above depth")
  `FQ_ASSERT(a_insert_count, (cmd.finish && item_op == OP_INSERT && res_status == STAT_OK) |=> (count_q == $past(count_q) + CW'(1)), "accepted insert did not add one record")
  `FQ_ASSERT(a_fail_zero, (rsp.valid && rsp.status != STAT_OK) |-> (rsp.out_handler == '0 && rsp.out_id == '0), "failed step returned record data")
  `FQ_ASSERT_ALWAYS(a_rst_idle, rst |=> !rsp.valid, "result valid after reset")

endmodule

FILE: design/sorted_priority_fault_queue.sv
// Channel | Dir | Fields
// req     | in  | op, fault_num, category, priority_req, handler_ref, param_ref
// rsp     | out | status, out_id, out_category, out_priority, out_handler, out_param, count
//
// One item at a time; records move through a single record RAM, one per cycle.
// Insert: decode, then one shift step per record moved back, then the new record is placed.
// Remove: decode, head read, then each remaining record moves down; rejected or empty steps end at decode.
// The controller returns to its idle state after each result.
// Synchronous reset empties the queue at once; no clearing pass.
// A new request is taken while the previous result waits in the output register;
// a stalled rsp holds only the final step.
module sorted_priority_fault_queue #(
  parameter int QUEUE_DEPTH = fq_pkg::QUEUE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  fq_in_if.sink    req,
  fq_out_if.source rsp
);
  import fq_pkg::*;

  fq_cmd_t  cmd;
  fq_stat_t stat;

  fq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .cmd (cmd)
  );

  fq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .stat(stat)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import fq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int CNT_W = 5;
  localparam int RANDOM_ITEMS = 1850;
  localparam int TAIL_CYCLES = DEPTH + 16;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam logic [PRI_W-1:0] FILL_PRI [16] = '{
    8'h80, 8'hff, 8'h00, 8'h80, 8'h7f, 8'h80, 8'h01, 8'hff,
    8'h00, 8'hfe, 8'h55, 8'haa, 8'h80, 8'h00, 8'hff, 8'h40
  };

  typedef struct packed {
    logic             op;
    logic [ID_W-1:0]  id;
    logic [CAT_W-1:0] cat;
    logic [PRI_W-1:0] pri;
    logic [REF_W-1:0] hnd;
    logic [REF_W-1:0] par;
  } fault_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [CAT_W-1:0]  cat;
    logic [PRI_W-1:0]  pri;
    logic [REF_W-1:0]  hnd;
    logic [REF_W-1:0]  par;
    logic [CNT_W-1:0]  count;
  } fault_rsp_t;

  class fault_queue_shadow;
    rec_t        slots [DEPTH];
    int unsigned stored;
    fault_rsp_t  due_results [$];
    int unsigned mismatches;

    function new();
      stored = 0;
      mismatches = 0;
    endfunction

    function string rsp_text(fault_rsp_t r);
      return $sformatf("status=%0d id=%02h cat=%02h pri=%02h hnd=%08h par=%08h count=%0d",
                       r.status, r.id, r.cat, r.pri, r.hnd, r.par, r.count);
    endfunction

    function void note_request(fault_req_t item);
      fault_rsp_t res;
      int pos;
      res = '0;
      if (item.op == OP_INSERT) begin
        if (stored >= DEPTH || item.hnd == '0) begin
          res.status = STAT_REJECT;
        end else begin
          pos = stored;
          while (pos > 0 && slots[pos-1].pri > item.pri) begin
            slots[pos] = slots[pos-1];
            pos--;
          end
          slots[pos] = '{pri: item.pri, id: item.id, cat: item.cat,
                         hnd: item.hnd, par: item.par};
          stored++;
          res.status = STAT_OK;
        end
      end else if (stored == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.status = STAT_OK;
        res.id = slots[0].id;
        res.cat = slots[0].cat;
        res.pri = slots[0].pri;
        res.hnd = slots[0].hnd;
        res.par = slots[0].par;
        for (int k = 1; k < stored; k++) slots[k-1] = slots[k];
        stored--;
      end
      res.count = CNT_W'(stored);
      due_results.push_back(res);
    endfunction

    function void check_response(fault_rsp_t act);
      fault_rsp_t exp_r;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result %s", $time, rsp_text(act));
        return;
      end
      exp_r = due_results.pop_front();
      if (act.status !== exp_r.status || act.id !== exp_r.id || act.cat !== exp_r.cat ||
          act.pri !== exp_r.pri || act.hnd !== exp_r.hnd || act.par !== exp_r.par ||
          act.count !== exp_r.count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                   rsp_text(exp_r), rsp_text(act));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   tight;

  fault_queue_shadow shadow = new();

  fq_in_if req_ch ();
  fq_out_if #(.CNT_W(CNT_W)) rsp_ch ();

  sorted_priority_fault_queue #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_gap();
    int r;
    if (tight) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic fault_req_t insert_item(logic [PRI_W-1:0] pri, logic [ID_W-1:0] id,
                                             logic [CAT_W-1:0] cat, logic [REF_W-1:0] hnd,
                                             logic [REF_W-1:0] par);
    fault_req_t item;
    item = '{op: OP_INSERT, id: id, cat: cat, pri: pri, hnd: hnd, par: par};
    return item;
  endfunction

  task automatic send_request(input fault_req_t item, input int gap);
    req_ch.valid <= 1'b1;
    req_ch.op <= item.op;
    req_ch.fault_num <= item.id;
    req_ch.category <= item.cat;
    req_ch.priority_req <= item.pri;
    req_ch.handler_ref <= item.hnd;
    req_ch.param_ref <= item.par;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    shadow.note_request(item);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (shadow.due_results.size() != 0);
  endtask

  initial begin
    fault_req_t remove_req;
    fault_req_t item;
    int ins_pct;
    bit narrow;
    remove_req = '0;
    remove_req.op = OP_REMOVE;
    ins_pct = 50;
    narrow = 1'b0;
    tight = 1'b0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_INSERT;
    req_ch.fault_num <= '0;
    req_ch.category <= '0;
    req_ch.priority_req <= '0;
    req_ch.handler_ref <= '0;
    req_ch.param_ref <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(remove_req, 0);
    send_request(insert_item(8'h10, 8'h01, 8'h02, 32'h0, 32'hffff_ffff), 0);
    for (int i = 0; i < DEPTH; i++) begin
      send_request(insert_item(FILL_PRI[i % 16], 8'(i), 8'(255 - i),
                               (i % 2) ? 32'hffff_ffff : 32'(i + 1),
                               (i % 2) ? 32'h0 : 32'hffff_ffff),
                   $urandom_range(0, 2));
    end
    send_request(insert_item(8'h00, 8'hff, 8'hff, 32'hdead_beef, 32'h1234_5678), 0);
    send_request(insert_item(8'h00, 8'h00, 8'h00, 32'h0, 32'hffff_ffff), 1);
    repeat (4) send_request(remove_req, $urandom_range(0, 1));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 25;
          1:       ins_pct = 50;
          default: ins_pct = 75;
        endcase
        narrow = 1'($urandom_range(0, 1));
        tight = ($urandom_range(0, 3) == 0);
        if (n == 400 || $urandom_range(0, 7) == 0) drain_results();
      end
      item.op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
      item.id = ID_W'($urandom);
      item.cat = CAT_W'($urandom);
      item.pri = narrow ? PRI_W'($urandom_range(0, 3)) : PRI_W'($urandom);
      item.hnd = ($urandom_range(0, 19) == 0) ? '0 : REF_W'($urandom);
      item.par = REF_W'($urandom);
      send_request(item, idle_gap());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.due_results.size() == 0) begin
      $display("sorted_priority_fault_queue regression: pass");
    end else begin
      $display("sorted_priority_fault_queue regression: fail");
    end
    $finish;
  end

  initial begin
    fault_rsp_t act;
    int stall_left;
    int results_seen;
    bit long_hold_done;
    stall_left = 0;
    results_seen = 0;
    long_hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        act.status = rsp_ch.status;
        act.id = rsp_ch.out_id;
        act.cat = rsp_ch.out_category;
        act.pri = rsp_ch.out_priority;
        act.hnd = rsp_ch.out_handler;
        act.par = rsp_ch.out_param;
        act.count = rsp_ch.count;
        shadow.check_response(act);
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (results_seen >= 300 && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD_CYCLES;
      end else begin
        stall_left = idle_gap();
      end
      rsp_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    #10_000_000;
    $display("sorted_priority_fault_queue regression: fail");
    $finish;
  end

endmodule
